/* rtl/core/p256fm_pkg.sv */
package p256fm_pkg;

  localparam int LIMB_W    = 32;
  localparam int NUM_LIMBS = 8;
  localparam int PROD_BITS = 2 * NUM_LIMBS * LIMB_W;
  localparam int FIELD_W   = NUM_LIMBS * LIMB_W;
  localparam int CNT_W     = $clog2(PROD_BITS);

  typedef logic [LIMB_W-1:0]                 limb_t;
  typedef logic [2*LIMB_W-1:0]               dlimb_t;
  typedef logic [FIELD_W-1:0]                fe_t;
  typedef logic [NUM_LIMBS-1:0][LIMB_W-1:0]  opnd_t;
  typedef logic [2*NUM_LIMBS-1:0][LIMB_W-1:0] prod_t;
  typedef logic [CNT_W-1:0]                  cnt_t;

  // p = 2^256 - 2^224 + 2^192 + 2^96 - 1
  localparam fe_t P256 =
    256'hffffffff_00000001_00000000_00000000_00000000_ffffffff_ffffffff_ffffffff;

  localparam logic [5:0] MUL_LAST = 6'd63;
  localparam cnt_t       RED_LAST = cnt_t'(PROD_BITS - 1);

endpackage

/* rtl/core/p256fm_mac.sv */
module p256fm_mac (
  input  p256fm_pkg::limb_t  a,
  input  p256fm_pkg::limb_t  b,
  input  p256fm_pkg::limb_t  acc,
  input  p256fm_pkg::limb_t  carry,
  output p256fm_pkg::dlimb_t sum
);
  import p256fm_pkg::*;

  dlimb_t prod;

  // a*b + acc + carry never exceeds 2^64 - 1
  assign prod = dlimb_t'(a) * dlimb_t'(b);
  assign sum  = prod + dlimb_t'(acc) + dlimb_t'(carry);

endmodule

/* rtl/core/p256fm_redstep.sv */
module p256fm_redstep (
  input  p256fm_pkg::fe_t rem_in,
  input  logic            bit_in,
  output p256fm_pkg::fe_t rem_out
);
  import p256fm_pkg::*;

  logic [FIELD_W:0]   shifted;
  logic [FIELD_W+1:0] diff;

  // rem_in < p, so the shifted value is below 2p and one subtract suffices
  assign shifted = {rem_in, bit_in};
  assign diff    = {1'b0, shifted} - {2'b00, P256};
  assign rem_out = diff[FIELD_W+1] ? shifted[FIELD_W-1:0] : diff[FIELD_W-1:0];

endmodule

/* rtl/core/p256_field_multiply.sv */
// P-256 field multiplier: takes two 256-bit factors (four 64-bit words each,
// least significant first, need not be reduced) and returns their product
// modulo p = 2^256 - 2^224 + 2^192 + 2^96 - 1, fully reduced into 0 .. p-1.
// From the accepting edge to the result beat an item takes these steps:
// 32x32 multiply-accumulate through one shared limb multiplier
// (one limb pair per cycle) builds the 512-bit product, then
// shift-and-conditional-subtract through one 258-bit subtractor reduces
// it, one product bit per cycle, then the residue moves into the output
// register, which then shows the result beat. in_stall is high from
// the accepting edge until the residue moves into the output register, so
// the next item can be accepted at the same edge as the earliest result beat.
// The result sits in an output register, so the next item is accepted while
// a result beat still waits; a residue finished while that register is still
// stalled holds the block in its last step.
module p256_field_multiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_left_word0,
  input  logic [63:0] in_left_word1,
  input  logic [63:0] in_left_word2,
  input  logic [63:0] in_left_word3,
  input  logic [63:0] in_right_word0,
  input  logic [63:0] in_right_word1,
  input  logic [63:0] in_right_word2,
  input  logic [63:0] in_right_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_residue_word0,
  output logic [63:0] out_residue_word1,
  output logic [63:0] out_residue_word2,
  output logic [63:0] out_residue_word3
);
  import p256fm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  opnd_t  a_r, a_nxt;
  opnd_t  b_r, b_nxt;
  prod_t  acc_r, acc_nxt;
  limb_t  carry_r, carry_nxt;
  fe_t    rem_r, rem_nxt;
  fe_t    res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [2:0] idx_i, idx_j;
  logic [3:0] idx_ij;
  dlimb_t     mac_sum;
  fe_t        step_rem;
  logic       in_beat, out_free;

  // limb pair selection: row i in the upper counter bits, column j in the lower
  assign idx_i  = cnt_r[5:3];
  assign idx_j  = cnt_r[2:0];
  assign idx_ij = {1'b0, idx_i} + {1'b0, idx_j};

  p256fm_mac u_mac (
    .a     (a_r[idx_i]),
    .b     (b_r[idx_j]),
    .acc   (acc_r[idx_ij]),
    .carry (carry_r),
    .sum   (mac_sum)
  );

  // product bits leave the top of acc_r, most significant first
  p256fm_redstep u_redstep (
    .rem_in  (rem_r),
    .bit_in  (acc_r[2*NUM_LIMBS-1][LIMB_W-1]),
    .rem_out (step_rem)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    carry_nxt     = carry_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          a_nxt     = {in_left_word3, in_left_word2, in_left_word1, in_left_word0};
          b_nxt     = {in_right_word3, in_right_word2, in_right_word1, in_right_word0};
          acc_nxt   = '0;
          carry_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt[idx_ij] = mac_sum[LIMB_W-1:0];
        if (idx_j == 3'd7) begin
          // end of a row: final carry lands in the still-empty limb i+8
          acc_nxt[{1'b1, idx_i}] = mac_sum[2*LIMB_W-1:LIMB_W];
          carry_nxt              = '0;
        end else begin
          carry_nxt = mac_sum[2*LIMB_W-1:LIMB_W];
        end
        if (cnt_r[5:0] == MUL_LAST) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = ST_RED;
        end else begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end
      ST_RED: begin
        acc_nxt = acc_r << 1;
        rem_nxt = step_rem;
        if (cnt_r == RED_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          res_nxt       = rem_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_residue_word0 = res_r[63:0];
  assign out_residue_word1 = res_r[127:64];
  assign out_residue_word2 = res_r[191:128];
  assign out_residue_word3 = res_r[255:192];

endmodule

/* rtl/core/p256fm_checker.sv */
module p256fm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_residue_word0,
  input logic [63:0] out_residue_word1,
  input logic [63:0] out_residue_word2,
  input logic [63:0] out_residue_word3
);
  import p256fm_pkg::*;

  fe_t residue;
  assign residue = {out_residue_word3, out_residue_word2, out_residue_word1,
                    out_residue_word0};

  // busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  // a new result only appears as the block returns to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while still busy");

  // residue is fully reduced
  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> residue < P256)
    else $error("residue not below p");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(residue))
    else $error("stalled result beat changed");

endmodule

bind p256_field_multiply p256fm_checker u_p256fm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_residue_word0 (out_residue_word0),
  .out_residue_word1 (out_residue_word1),
  .out_residue_word2 (out_residue_word2),
  .out_residue_word3 (out_residue_word3)
);
